// ===== src/icbb_pkg.sv =====
package icbb_pkg;

  localparam int unsigned RomBanksDefault = 32;
  localparam int unsigned BankWidth       = 5;

  // Address decode masks and matches
  localparam logic [15:0] CtrlMask    = 16'hBF04;
  localparam logic [15:0] CtrlMatch   = 16'h0104;
  localparam logic [15:0] DataMask    = 16'h3E00;
  localparam logic [15:0] DataMatch   = 16'h3C00;
  localparam logic [15:0] RegMask     = 16'h3F00;
  localparam logic [15:0] RegMatch    = 16'h3E00;

  localparam logic [7:0]  CtrlReset   = 8'hFF;
  localparam logic [7:0]  Unmapped    = 8'hFF;
  localparam logic [7:0]  SrstStatus  = 8'hFF;
  localparam logic [7:0]  SrstOther   = 8'h7F;
  localparam logic [7:0]  DevMaskKeep = 8'hEF;

  localparam logic [3:0]  RegData     = 4'd0;
  localparam logic [3:0]  RegDevHead  = 4'd6;
  localparam logic [3:0]  RegStatus   = 4'd7;
  localparam logic [3:0]  RegAltStat  = 4'd14;

  localparam int unsigned DevBit      = 4;
  localparam int unsigned SrstBit     = 2;

  typedef enum logic [2:0] {
    CMD_NONE    = 3'd0,
    CMD_DATA_RD = 3'd1,
    CMD_DATA_WR = 3'd2,
    CMD_REG_RD  = 3'd3,
    CMD_REG_WR  = 3'd4,
    CMD_RESET   = 3'd5
  } cmd_e;

  typedef struct packed {
    logic        opcode;
    logic [15:0] address;
    logic [7:0]  write_value;
    logic [15:0] drive_data_in;
  } in_t;

  typedef struct packed {
    logic [7:0]  read_value;
    logic        from_rom;
    logic [18:0] rom_address;
    cmd_e        drive_command;
    logic        drive_select;
    logic [3:0]  drive_register;
    logic [15:0] drive_write_data;
  } out_t;

  typedef struct packed {
    logic [7:0] control;
    logic [7:0] read_high;
    logic [7:0] write_low;
    logic       drive_sel;
    logic       srst;
  } state_t;

endpackage

// ===== src/ide_cartridge_bus_bridge.sv =====
// Channel | Signals                          | Moves
// --------+----------------------------------+-------------------------------
// in      | in_valid_i in_ready_o in_data_i  | one CPU bus access word
// out     | out_valid_o out_ready_i out_data_o | one decoded result word
//
// An access is registered on input, decoded against the bridge state and
// lands in the result register: one word per cycle sustained while the
// output does not stall, set by the single decode stage.
// Reset clears both stages and loads the control register with 0xFF.
// A stalled output holds the result register; the input stage then holds too
// and in_ready_o drops once it is full.
module ide_cartridge_bus_bridge #(
  parameter int unsigned RomBanks = icbb_pkg::RomBanksDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  icbb_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output icbb_pkg::out_t out_data_o
);

  logic             in_valid_q;
  icbb_pkg::in_t    in_data_q;
  logic             out_valid_q;
  icbb_pkg::out_t   out_data_q;
  icbb_pkg::out_t   out_data_d;
  icbb_pkg::state_t state_q;
  icbb_pkg::state_t state_d;
  logic             out_free;
  logic             advance;

  assign out_free   = !out_valid_q || out_ready_i;
  assign advance    = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_data_q <= in_data_i;
    end
  end

  icbb_decode #(
    .RomBanks(RomBanks)
  ) u_decode (
    .item_i  (in_data_q),
    .state_i (state_q),
    .result_o(out_data_d),
    .state_o (state_d)
  );

  icbb_state u_state (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .state_i(state_d),
    .state_o(state_q)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_hold_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !out_free |=> in_valid_q && $stable(in_data_q))
    else $error("input stage lost a word while stalled");

  a_srst_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && out_data_d.drive_command == icbb_pkg::CMD_RESET |=> state_q.srst)
    else $error("soft reset not recorded after reset command");

  a_rom_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.from_rom |->
      out_data_o.drive_command == icbb_pkg::CMD_NONE && out_data_o.read_value == 8'h00)
    else $error("ROM read carries a drive command or read byte");

  a_reg_field: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.drive_register != 4'd0 |->
      out_data_o.drive_command == icbb_pkg::CMD_REG_RD ||
      out_data_o.drive_command == icbb_pkg::CMD_REG_WR)
    else $error("register number without register command");

endmodule

// ===== src/icbb_decode.sv =====
module icbb_decode #(
  parameter int unsigned RomBanks = icbb_pkg::RomBanksDefault
) (
  input  icbb_pkg::in_t    item_i,
  input  icbb_pkg::state_t state_i,
  output icbb_pkg::out_t   result_o,
  output icbb_pkg::state_t state_o
);

  localparam logic [icbb_pkg::BankWidth:0] BanksLim = (icbb_pkg::BankWidth + 1)'(RomBanks);
  localparam logic [icbb_pkg::BankWidth-1:0] BankMask =
    icbb_pkg::BankWidth'(RomBanks - 1);

  logic                           ide_on;
  logic                           data_win;
  logic                           reg_win;
  logic                           rom_win;
  logic                           ctrl_hit;
  logic [3:0]                     reg_num;
  logic [3:0]                     rd_reg;
  logic [icbb_pkg::BankWidth-1:0] bank_raw;
  logic [icbb_pkg::BankWidth-1:0] bank;
  logic [15:0]                    addr;
  logic [7:0]                     val;
  logic                           new_sel;

  assign addr     = item_i.address;
  assign val      = item_i.write_value;
  assign ide_on   = state_i.control[0];
  assign data_win = ide_on && ((addr & icbb_pkg::DataMask) == icbb_pkg::DataMatch);
  assign reg_win  = ide_on && ((addr & icbb_pkg::RegMask) == icbb_pkg::RegMatch);
  assign rom_win  = (addr[15:14] == 2'b01);
  assign ctrl_hit = ((addr & icbb_pkg::CtrlMask) == icbb_pkg::CtrlMatch);
  assign reg_num  = addr[3:0];
  // alternate status reads as status
  assign rd_reg   = (reg_num == icbb_pkg::RegAltStat) ? icbb_pkg::RegStatus : reg_num;
  assign new_sel  = val[icbb_pkg::DevBit];

  // bank number sits bit-reversed in control[7:3]
  always_comb begin
    for (int i = 0; i < icbb_pkg::BankWidth; i++) begin
      bank_raw[i] = state_i.control[7 - i];
    end
    if ({1'b0, bank_raw} >= BanksLim) begin
      bank = bank_raw & BankMask;
    end else begin
      bank = bank_raw;
    end
  end

  always_comb begin
    result_o = '0;
    state_o  = state_i;
    if (!item_i.opcode) begin
      priority if (data_win) begin
        if (!addr[0]) begin
          result_o.drive_command = icbb_pkg::CMD_DATA_RD;
          result_o.drive_select  = state_i.drive_sel;
          result_o.read_value    = item_i.drive_data_in[7:0];
          state_o.read_high      = item_i.drive_data_in[15:8];
        end else begin
          result_o.read_value = state_i.read_high;
        end
      end else if (reg_win) begin
        priority if (state_i.srst) begin
          result_o.read_value = (rd_reg == icbb_pkg::RegStatus) ? icbb_pkg::SrstStatus
                                                                : icbb_pkg::SrstOther;
        end else if (rd_reg == icbb_pkg::RegData) begin
          result_o.drive_command = icbb_pkg::CMD_DATA_RD;
          result_o.drive_select  = state_i.drive_sel;
          result_o.read_value    = item_i.drive_data_in[7:0];
        end else begin
          result_o.drive_command  = icbb_pkg::CMD_REG_RD;
          result_o.drive_select   = state_i.drive_sel;
          result_o.drive_register = rd_reg;
          result_o.read_value     = item_i.drive_data_in[7:0];
          if (rd_reg == icbb_pkg::RegDevHead) begin
            result_o.read_value = (item_i.drive_data_in[7:0] & icbb_pkg::DevMaskKeep) |
                                  (8'(state_i.drive_sel) << icbb_pkg::DevBit);
          end
        end
      end else if (rom_win) begin
        result_o.from_rom    = 1'b1;
        result_o.rom_address = {bank, addr[13:0]};
      end else begin
        result_o.read_value = icbb_pkg::Unmapped;
      end
    end else begin
      priority if (ctrl_hit) begin
        state_o.control = val;
      end else if (data_win) begin
        if (!addr[0]) begin
          state_o.write_low = val;
        end else begin
          result_o.drive_command    = icbb_pkg::CMD_DATA_WR;
          result_o.drive_select     = state_i.drive_sel;
          result_o.drive_write_data = {val, state_i.write_low};
        end
      end else if (reg_win) begin
        priority if (state_i.srst) begin
          // only a clear of SRST gets through
          if (reg_num == icbb_pkg::RegAltStat && !val[icbb_pkg::SrstBit]) begin
            state_o.srst = 1'b0;
          end
        end else if (reg_num == icbb_pkg::RegData) begin
          result_o.drive_command    = icbb_pkg::CMD_DATA_WR;
          result_o.drive_select     = state_i.drive_sel;
          result_o.drive_write_data = {val, val};
        end else if (reg_num == icbb_pkg::RegAltStat && val[icbb_pkg::SrstBit]) begin
          state_o.srst           = 1'b1;
          result_o.drive_command = icbb_pkg::CMD_RESET;
        end else begin
          result_o.drive_command    = icbb_pkg::CMD_REG_WR;
          result_o.drive_register   = reg_num;
          result_o.drive_write_data = {8'h00, val};
          if (reg_num == icbb_pkg::RegDevHead) begin
            state_o.drive_sel     = new_sel;
            result_o.drive_select = new_sel;
          end else begin
            result_o.drive_select = state_i.drive_sel;
          end
        end
      end
    end
  end

endmodule

// ===== src/icbb_state.sv =====
module icbb_state (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  icbb_pkg::state_t state_i,
  output icbb_pkg::state_t state_o
);

  icbb_pkg::state_t state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.control   <= icbb_pkg::CtrlReset;
      state_q.read_high <= '0;
      state_q.write_low <= '0;
      state_q.drive_sel <= 1'b0;
      state_q.srst      <= 1'b0;
    end else if (step_i) begin
      state_q <= state_i;
    end
  end

  assign state_o = state_q;

endmodule
